/* hw/rtl/ugti_pkg.sv */
// Shared types, constants and helpers for the trilinear interpolation block.
// Used by every module under hw/rtl except ugti_ram; depends on nothing else.
package ugti_pkg;

  localparam int POINTS_X = 16;
  localparam int POINTS_Y = 16;
  localparam int POINTS_Z = 16;

  // index fields are fixed at 4 bits wide
  localparam int IDX_W   = 4;
  localparam int BANK_AW = 3 * (IDX_W - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int NUM_BANKS  = 8;
  localparam int DATA_W  = 32;
  localparam int WGT_W   = 17;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX = 3'd6;

  localparam logic [DATA_W-1:0] INV_STEP_RESET = 32'h0001_0000;
  localparam logic [23:0]       LAST_RESET     = 24'h0F0F0F;
  localparam logic [WGT_W-1:0]  WGT_ONE        = 17'h10000;

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Stage payload for the front of the pipeline
  typedef struct packed {
    logic              query;
    logic [IDX_W-1:0]  ix;
    logic [IDX_W-1:0]  iy;
    logic [IDX_W-1:0]  iz;
    logic [DATA_W-1:0] value;
  } pipe_req_t;

  // Saturate one last-index field to 1..points-1
  function automatic logic [IDX_W-1:0] sat_last(input logic [7:0] raw,
                                                input logic [8:0] points);
    logic [8:0] lim;
    lim = points - 9'd1;
    if (raw == 8'd0) begin
      sat_last = IDX_W'(1);
    end else if ({1'b0, raw} > lim) begin
      sat_last = lim[IDX_W-1:0];
    end else begin
      sat_last = raw[IDX_W-1:0];
    end
  endfunction

endpackage

/* hw/rtl/ugti_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module ugti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, hold while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/ugti_locate.sv */
// Axis mapping: coordinate to cell index and Q1.16 weight in three stages.
// Depends on ugti_pkg.
module ugti_locate (
  input  logic                            clk,
  input  logic                            en,
  input  logic [ugti_pkg::DATA_W-1:0]     coord,
  input  logic [ugti_pkg::DATA_W-1:0]     origin,
  input  logic [ugti_pkg::DATA_W-1:0]     inv_step,
  input  logic [ugti_pkg::IDX_W-1:0]      last,
  output logic [ugti_pkg::IDX_W-1:0]      cell_idx,
  output logic [ugti_pkg::WGT_W-1:0]      wgt
);
  import ugti_pkg::*;

  logic signed [DATA_W:0] diff;
  logic                   pos1;
  logic [DATA_W-1:0]      dmag;
  logic                   pos2;
  logic [2*DATA_W-1:0]    prod;
  logic [DATA_W-1:0]      last_m1;

  // exact difference, sign extended
  assign diff = $signed({coord[DATA_W-1], coord}) - $signed({origin[DATA_W-1], origin});
  assign last_m1 = DATA_W'(last) - DATA_W'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: above-origin flag and magnitude
      pos1 <= !diff[DATA_W] && (diff != '0);
      dmag <= diff[DATA_W-1:0];
      // stage 2: scale by inverse spacing
      pos2 <= pos1;
      prod <= dmag * inv_step;
      // stage 3: clamp to the grid
      if (!pos2) begin
        cell_idx <= '0;
        wgt      <= '0;
      end else if (prod[2*DATA_W-1:DATA_W] > last_m1) begin
        cell_idx <= last_m1[IDX_W-1:0];
        wgt      <= WGT_ONE;
      end else begin
        cell_idx <= prod[DATA_W+IDX_W-1:DATA_W];
        wgt      <= {1'b0, prod[DATA_W-1:DATA_W-16]};
      end
    end
  end

endmodule

/* hw/rtl/ugti_blend.sv */
// One linear blend lane, two stages: a + round((b - a) * w / 65536).
// Depends on ugti_pkg.
module ugti_blend (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ugti_pkg::DATA_W-1:0] a,
  input  logic [ugti_pkg::DATA_W-1:0] b,
  input  logic [ugti_pkg::WGT_W-1:0]  wgt,
  output logic [ugti_pkg::DATA_W-1:0] r
);
  import ugti_pkg::*;

  localparam int PROD_W = DATA_W + 1 + WGT_W + 1;

  logic signed [DATA_W:0]   delta;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd;
  logic [DATA_W-1:0]        a_q;

  assign delta = $signed({b[DATA_W-1], b}) - $signed({a[DATA_W-1], a});
  assign rnd   = (prod + PROD_W'(32768)) >>> 16;

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: weighted difference
      prod <= PROD_W'(delta * $signed({1'b0, wgt}));
      a_q  <= a;
      // stage 2: round to nearest and add back the base
      r    <= a_q + rnd[DATA_W-1:0];
    end
  end

endmodule

/* hw/rtl/uniform_grid_trilinear_interp.sv */
// Trilinear interpolation over a 16x16x16 Q16.16 sample grid.
// A query result passes three axis-mapping stages, one RAM read and two
// stages per blend level.
// Throughput: one item per cycle unless stalled; the eight corners come from
// eight parity-banked RAMs with one read port each. A stall holds every stage.
// Reset clears valid bits and returns the configuration registers to their
// defaults; the sample table is undefined until written.
module uniform_grid_trilinear_interp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            req_type,
  input  logic [ugti_pkg::DATA_W-1:0]     coord_x,
  input  logic [ugti_pkg::DATA_W-1:0]     coord_y,
  input  logic [ugti_pkg::DATA_W-1:0]     coord_z,
  input  logic [ugti_pkg::IDX_W-1:0]      entry_ix,
  input  logic [ugti_pkg::IDX_W-1:0]      entry_iy,
  input  logic [ugti_pkg::IDX_W-1:0]      entry_iz,
  input  logic [ugti_pkg::DATA_W-1:0]     entry_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ugti_pkg::DATA_W-1:0]     interp_value,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ugti_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ugti_pkg::DATA_W-1:0]     cfg_data
);
  import ugti_pkg::*;

  logic [DATA_W-1:0] origin_x, origin_y, origin_z;
  logic [DATA_W-1:0] inv_step_x, inv_step_y, inv_step_z;
  logic [23:0]       last_index_xyz;
  logic [IDX_W-1:0]  last_x, last_y, last_z;

  logic              en;
  logic [3:1]        v;
  pipe_req_t         req [3:1];
  pipe_req_t         req_in;
  logic [10:4]       qv;

  logic [IDX_W-1:0]  cx, cy, cz;
  logic [WGT_W-1:0]  wx, wy, wz;
  logic [IDX_W-1:0]  cx1, cy1, cz1;

  logic              px4, py4, pz4;
  logic [WGT_W-1:0]  wx4, wy4, wz4, wy5, wz5, wy6, wz6, wz7, wz8;
  logic [DATA_W-1:0] bank_q [NUM_BANKS];
  logic [DATA_W-1:0] corner [NUM_BANKS];
  logic [DATA_W-1:0] fx [4];
  logic [DATA_W-1:0] fy [2];

  assign cfg_ready = 1'b1;
  assign en        = !qv[10] || out_ready;
  assign in_ready  = en;
  assign out_valid = qv[10];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x       <= '0;
      origin_y       <= '0;
      origin_z       <= '0;
      inv_step_x     <= INV_STEP_RESET;
      inv_step_y     <= INV_STEP_RESET;
      inv_step_z     <= INV_STEP_RESET;
      last_index_xyz <= LAST_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORIGIN_X:   origin_x       <= cfg_data;
        REG_ORIGIN_Y:   origin_y       <= cfg_data;
        REG_ORIGIN_Z:   origin_z       <= cfg_data;
        REG_INV_STEP_X: inv_step_x     <= cfg_data;
        REG_INV_STEP_Y: inv_step_y     <= cfg_data;
        REG_INV_STEP_Z: inv_step_z     <= cfg_data;
        REG_LAST_INDEX: last_index_xyz <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  assign last_x = sat_last(last_index_xyz[7:0],   9'(POINTS_X));
  assign last_y = sat_last(last_index_xyz[15:8],  9'(POINTS_Y));
  assign last_z = sat_last(last_index_xyz[23:16], 9'(POINTS_Z));

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v  <= '0;
      qv <= '0;
    end else if (en) begin
      v[1]     <= in_valid;
      v[3:2]   <= v[2:1];
      qv[4]    <= v[3] && (req[3].query == REQ_QUERY);
      qv[10:5] <= qv[9:4];
    end
  end

  // carry request payload alongside the axis mapping
  always_comb begin
    req_in.query = req_type;
    req_in.ix    = entry_ix;
    req_in.iy    = entry_iy;
    req_in.iz    = entry_iz;
    req_in.value = entry_value;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req[1] <= req_in;
      req[2] <= req[1];
      req[3] <= req[2];
    end
  end

  ugti_locate u_loc_x (
    .clk(clk), .en(en), .coord(coord_x), .origin(origin_x),
    .inv_step(inv_step_x), .last(last_x), .cell_idx(cx), .wgt(wx)
  );
  ugti_locate u_loc_y (
    .clk(clk), .en(en), .coord(coord_y), .origin(origin_y),
    .inv_step(inv_step_y), .last(last_y), .cell_idx(cy), .wgt(wy)
  );
  ugti_locate u_loc_z (
    .clk(clk), .en(en), .coord(coord_z), .origin(origin_z),
    .inv_step(inv_step_z), .last(last_z), .cell_idx(cz), .wgt(wz)
  );

  assign cx1 = cx + IDX_W'(1);
  assign cy1 = cy + IDX_W'(1);
  assign cz1 = cz + IDX_W'(1);

  // eight banks split by index parity; writes and reads share one stage
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    localparam logic BX = 1'(b & 1);
    localparam logic BY = 1'((b >> 1) & 1);
    localparam logic BZ = 1'((b >> 2) & 1);
    logic [IDX_W-2:0]   ax, ay, az;
    logic [BANK_AW-1:0] raddr, waddr;
    logic               we, re;

    assign ax    = (cx[0] == BX) ? cx[IDX_W-1:1] : cx1[IDX_W-1:1];
    assign ay    = (cy[0] == BY) ? cy[IDX_W-1:1] : cy1[IDX_W-1:1];
    assign az    = (cz[0] == BZ) ? cz[IDX_W-1:1] : cz1[IDX_W-1:1];
    assign raddr = {az, ay, ax};
    assign waddr = {req[3].iz[IDX_W-1:1], req[3].iy[IDX_W-1:1], req[3].ix[IDX_W-1:1]};
    assign re    = en && v[3] && (req[3].query == REQ_QUERY);
    assign we    = en && v[3] && (req[3].query == REQ_WRITE) &&
                   (req[3].ix[0] == BX) && (req[3].iy[0] == BY) && (req[3].iz[0] == BZ);

    ugti_ram #(.WIDTH(DATA_W), .DEPTH(BANK_DEPTH)) u_ram (
      .clk(clk), .we(we), .waddr(waddr), .wdata(req[3].value),
      .re(re), .raddr(raddr), .rdata(bank_q[b])
    );
  end

  // align parity and weights with the read data and each blend level
  always_ff @(posedge clk) begin
    if (en) begin
      px4 <= cx[0];
      py4 <= cy[0];
      pz4 <= cz[0];
      wx4 <= wx;
      wy4 <= wy;
      wz4 <= wz;
      wy5 <= wy4;
      wy6 <= wy5;
      wz5 <= wz4;
      wz6 <= wz5;
      wz7 <= wz6;
      wz8 <= wz7;
    end
  end

  // route banks to corners: corner index is {dz, dy, dx}
  always_comb begin
    for (int c = 0; c < NUM_BANKS; c++) begin
      corner[c] = bank_q[{c[2] ^ pz4, c[1] ^ py4, c[0] ^ px4}];
    end
  end

  // blend along x, then y, then z
  for (genvar k = 0; k < 4; k++) begin : g_bx
    ugti_blend u_bx (
      .clk(clk), .en(en), .a(corner[2*k]), .b(corner[2*k+1]), .wgt(wx4), .r(fx[k])
    );
  end

  for (genvar k = 0; k < 2; k++) begin : g_by
    ugti_blend u_by (
      .clk(clk), .en(en), .a(fx[2*k]), .b(fx[2*k+1]), .wgt(wy6), .r(fy[k])
    );
  end

  ugti_blend u_bz (
    .clk(clk), .en(en), .a(fy[0]), .b(fy[1]), .wgt(wz8), .r(interp_value)
  );

endmodule

/* test/uniform_grid_trilinear_interp_tb.sv */
// Testbench for uniform_grid_trilinear_interp: fills the reachable part of the
// sample table, runs directed and random queries over several grid settings.
// Depends on ugti_pkg and the block's RTL only.
module uniform_grid_trilinear_interp_tb;
  import ugti_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 14;
  localparam int NUM_CFG = 8;

  // Grid predictor and store of expected interpolated values
  class interp_scoreboard;
    bit [31:0] org[3];
    bit [31:0] inv[3];
    bit [23:0] last_xyz;
    bit [31:0] samples[POINTS_X*POINTS_Y*POINTS_Z];
    bit [31:0] pending_values[$];
    int errors;
    int results_seen;
    int queries_seen;

    function new();
      for (int a = 0; a < 3; a++) begin
        org[a] = '0;
        inv[a] = INV_STEP_RESET;
      end
      last_xyz = LAST_RESET;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, bit [31:0] data);
      case (idx)
        REG_ORIGIN_X:   org[0] = data;
        REG_ORIGIN_Y:   org[1] = data;
        REG_ORIGIN_Z:   org[2] = data;
        REG_INV_STEP_X: inv[0] = data;
        REG_INV_STEP_Y: inv[1] = data;
        REG_INV_STEP_Z: inv[2] = data;
        REG_LAST_INDEX: last_xyz = data[23:0];
        default: ;
      endcase
    endfunction

    function int last_of(int axis);
      int l;
      l = (last_xyz >> (8 * axis)) & 255;
      if (l < 1) l = 1;
      if (l > POINTS_X - 1) l = POINTS_X - 1;
      return l;
    endfunction

    // Map one coordinate to a cell and a Q1.16 weight
    function void locate(int axis, bit [31:0] coord, output int cell_idx, output longint w);
      longint d;
      longint unsigned p, idx;
      int l;
      l = last_of(axis);
      d = longint'($signed(coord)) - longint'($signed(org[axis]));
      if (d <= 0) begin
        cell_idx = 0;
        w = 0;
      end else begin
        p = longint'(d) * longint'({32'd0, inv[axis]});
        idx = p >> 32;
        if (idx > longint'(l - 1)) begin
          cell_idx = l - 1;
          w = 65536;
        end else begin
          cell_idx = int'(idx);
          w = longint'((p >> 16) & 64'hFFFF);
        end
      end
    endfunction

    function longint lerp(longint a, longint b, longint w);
      longint s, r;
      s = a * (65536 - w) + b * w + 32768;
      r = s >>> 16;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r;
    endfunction

    function longint sample_at(int ix, int iy, int iz);
      return longint'($signed(samples[(iz * POINTS_Y + iy) * POINTS_X + ix]));
    endfunction

    // Note one accepted input transfer
    function void note_item(bit query, bit [31:0] cx, bit [31:0] cy, bit [31:0] cz,
                            bit [3:0] ix, bit [3:0] iy, bit [3:0] iz, bit [31:0] val);
      int x, y, z;
      longint wx, wy, wz, f11, f21, f12, f22, f1, f2, r;
      if (query == REQ_WRITE) begin
        samples[(int'(iz) * POINTS_Y + int'(iy)) * POINTS_X + int'(ix)] = val;
        return;
      end
      locate(0, cx, x, wx);
      locate(1, cy, y, wy);
      locate(2, cz, z, wz);
      f11 = lerp(sample_at(x, y, z), sample_at(x + 1, y, z), wx);
      f21 = lerp(sample_at(x, y + 1, z), sample_at(x + 1, y + 1, z), wx);
      f12 = lerp(sample_at(x, y, z + 1), sample_at(x + 1, y, z + 1), wx);
      f22 = lerp(sample_at(x, y + 1, z + 1), sample_at(x + 1, y + 1, z + 1), wx);
      f1 = lerp(f11, f21, wy);
      f2 = lerp(f12, f22, wy);
      r = lerp(f1, f2, wz);
      pending_values.push_back(r[31:0]);
      queries_seen++;
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    // Check one result transfer against the oldest expectation
    task check_result(bit [31:0] got);
      bit [31:0] want;
      results_seen++;
      if (pending_values.size() == 0) begin
        report($sformatf("unexpected result %h", got));
      end else begin
        want = pending_values.pop_front();
        if (got !== want) report($sformatf("interp_value %h, expected %h", got, want));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic in_valid, in_ready;
  logic req_type;
  logic [31:0] coord_x, coord_y, coord_z;
  logic [3:0] entry_ix, entry_iy, entry_iz;
  logic [31:0] entry_value;
  logic out_valid, out_ready;
  logic [31:0] interp_value;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  interp_scoreboard sb;
  int cycle_count;
  int hold_request;
  int stall_mode;
  int burst_left;
  logic [CFG_IDX_W-1:0] reg_order[7];
  bit [31:0] grid_cfg[NUM_CFG][7];

  uniform_grid_trilinear_interp u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .entry_ix(entry_ix), .entry_iy(entry_iy), .entry_iz(entry_iz),
    .entry_value(entry_value),
    .out_valid(out_valid), .out_ready(out_ready), .interp_value(interp_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial sb = new();

  // Watch both channels; give up at the cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL uniform_grid_trilinear_interp");
      $finish;
    end
    if (!rst && in_valid && in_ready)
      sb.note_item(req_type, coord_x, coord_y, coord_z,
                   entry_ix, entry_iy, entry_iz, entry_value);
    if (!rst && out_valid && out_ready) sb.check_result(interp_value);
  end

  // Receiver: random stalls, stall-free stretches, and long hold-offs on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_mode == 0) begin
        out_ready <= 1'b1;
      end else if (stall_mode == 1) begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end else begin
        out_ready <= ($urandom_range(0, 2) == 0);
      end
    end
  end

  // Offer one item and hold it until the transfer; gaps fall between bursts
  task send_item(bit query, bit [31:0] cx, bit [31:0] cy, bit [31:0] cz,
                 bit [3:0] ix, bit [3:0] iy, bit [3:0] iz, bit [31:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    req_type <= query;
    coord_x <= cx;
    coord_y <= cy;
    coord_z <= cz;
    entry_ix <= ix;
    entry_iy <= iy;
    entry_iz <= iz;
    entry_value <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  task send_write(int ix, int iy, int iz, bit [31:0] val);
    send_item(REQ_WRITE, $urandom, $urandom, $urandom, 4'(ix), 4'(iy), 4'(iz), val);
  endtask

  task send_query(bit [31:0] cx, bit [31:0] cy, bit [31:0] cz);
    send_item(REQ_QUERY, cx, cy, cz, 4'($urandom), 4'($urandom), 4'($urandom), $urandom);
  endtask

  // Stop offering and wait until every expected result has come
  task drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, bit [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
  endtask

  // Program one full grid setting, then release the write channel
  task apply_cfg(int ph);
    for (int r = 0; r < 7; r++) write_reg(reg_order[r], grid_cfg[ph][r]);
    cfg_valid <= 1'b0;
  endtask

  // Write every entry of a box anchored at the table origin
  task fill_box(int nx, int ny, int nz);
    for (int iz = 0; iz < nz; iz++)
      for (int iy = 0; iy < ny; iy++)
        for (int ix = 0; ix < nx; ix++)
          send_write(ix, iy, iz, $urandom_range(0, 3) == 0 ? $urandom_range(0, 5 << 16)
                                                            : $urandom);
  endtask

  // Last-index word that stays inside the six-point base box
  function bit [31:0] small_last();
    return {8'd0, 8'($urandom_range(0, 5)), 8'($urandom_range(0, 5)),
            8'($urandom_range(0, 5))};
  endfunction

  // Near the grid most of the time, anywhere otherwise
  function bit [31:0] pick_coord(int axis);
    if ($urandom_range(0, 3) == 0) return $urandom;
    return sb.org[axis] + $urandom_range(0, 20 << 16) - (1 << 16);
  endfunction

  task random_items(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 3)
        send_write($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom);
      else
        send_query(pick_coord(0), pick_coord(1), pick_coord(2));
    end
  endtask

  initial begin
    reg_order = '{REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z, REG_INV_STEP_X,
                  REG_INV_STEP_Y, REG_INV_STEP_Z, REG_LAST_INDEX};
    // every setting keeps queries inside the boxes written below
    grid_cfg[0] = '{32'h0, 32'h0, 32'h0, INV_STEP_RESET, INV_STEP_RESET, INV_STEP_RESET,
                    32'h05_05_05};
    grid_cfg[1] = '{32'hFFFC_8000, 32'h0002_4000, 32'h0000_0000, 32'h0002_0000,
                    32'h0000_8000, 32'h0001_8000, 32'h03_04_05};
    grid_cfg[2] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                    32'h0000_0001, 32'h0001_0000, 32'h00_00_00};
    grid_cfg[3] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                    32'hFFFF_FFFF, 32'h0000_0000, 32'h02_02_02};
    grid_cfg[4] = '{$urandom, $urandom, $urandom, $urandom_range(1, 32'h0004_0000),
                    $urandom_range(1, 32'h0004_0000), $urandom, small_last()};
    grid_cfg[5] = '{32'h0, 32'h0, 32'h0, INV_STEP_RESET, INV_STEP_RESET, INV_STEP_RESET,
                    32'h02_02_FF};
    grid_cfg[6] = '{32'h0, 32'h0, 32'h0, INV_STEP_RESET, 32'h0000_C000, INV_STEP_RESET,
                    32'h02_FF_02};
    grid_cfg[7] = '{32'h0, 32'h0, 32'h0, INV_STEP_RESET, INV_STEP_RESET, 32'h0001_4000,
                    32'hFF_02_02};
    cycle_count = 0;
    hold_request = 0;
    stall_mode = 0;
    burst_left = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_WRITE;
    coord_x = '0;
    coord_y = '0;
    coord_z = '0;
    entry_ix = '0;
    entry_iy = '0;
    entry_iz = '0;
    entry_value = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ORIGIN_X;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill a base box plus one full-length row box per axis
    fill_box(6, 6, 6);
    fill_box(16, 3, 3);
    fill_box(3, 16, 3);
    fill_box(3, 3, 16);
    drain();
    apply_cfg(0);

    // Directed: extreme samples, grid points, below, above, fractions
    send_write(0, 0, 0, 32'h7FFF_FFFF);
    send_write(1, 0, 0, 32'h8000_0000);
    send_write(5, 5, 5, 32'h8000_0000);
    send_write(4, 5, 5, 32'h7FFF_FFFF);
    send_query(32'h0, 32'h0, 32'h0);
    send_query(32'h0000_8000, 32'h0, 32'h0);
    send_query(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
    send_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_query(32'h0004_8000, 32'h0005_0000, 32'h0005_0000);
    send_query(32'h0005_0000, 32'h0004_0000, 32'h0006_0000);
    send_query(32'h0001_4000, 32'h0003_C000, 32'h0002_0001);
    send_query(32'hFFFF_FFFF, 32'h0000_0001, 32'h0003_0000);
    send_query(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    send_query(32'hFFFF_0000, 32'h0004_FFFF, 32'h0000_0001);

    // Long hold-off on the result side while items keep coming
    hold_request = 300;
    random_items(200);
    drain();

    for (int ph = 1; ph < NUM_CFG; ph++) begin
      apply_cfg(ph);
      random_items(40);
      drain();
      random_items(60);
      drain();
    end

    drain();
    $display("covered %0d queries and %0d results over %0d grid settings",
             sb.queries_seen, sb.results_seen, NUM_CFG);
    $display("origin, step and last-index extremes included, with output hold-offs");
    if (sb.errors == 0 && sb.pending_values.size() == 0) begin
      $display("PASS uniform_grid_trilinear_interp");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending_values.size());
      $display("FAIL uniform_grid_trilinear_interp");
    end
    $finish;
  end

endmodule

/* uniform_grid_trilinear_interp.f */
hw/rtl/ugti_pkg.sv
hw/rtl/ugti_ram.sv
hw/rtl/ugti_locate.sv
hw/rtl/ugti_blend.sv
hw/rtl/uniform_grid_trilinear_interp.sv
test/uniform_grid_trilinear_interp_tb.sv
